// File: hw/rtl/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants for the UTF-8 stream decoder: byte classes,
// result status codes and the classified byte carried through the queue.
// ----------------------------------------------------------------------------
package utf8d_pkg;

   localparam int BYTE_W          = 8;
   localparam int CP_W            = 26;
   localparam int REM_W           = 3;
   localparam int QUEUE_DEPTH_DEF = 4;

   // class of one byte, decided in the front before the state is known
   typedef enum logic [2:0] {
      CLS_ASCII,    // 00-7F
      CLS_CONT,     // 80-BF
      CLS_LEAD2,    // C0-DF
      CLS_LEAD3,    // E0-EF
      CLS_LEAD4,    // F0-F7
      CLS_LEAD5,    // F8-FB
      CLS_INVALID   // FC-FF
   } byte_class_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_CHAR            = 2'd0,
      ST_MALFORMED       = 2'd1,
      ST_INCOMPLETE      = 2'd2,
      ST_END_AFTER_ERROR = 2'd3
   } status_type;

   // classified byte as it travels from front to back
   typedef struct packed {
      byte_class_type    cls;
      logic [BYTE_W-1:0] data;
      logic              last;
   } item_type;

endpackage

// File: hw/rtl/utf8d_if.sv
// ----------------------------------------------------------------------------
// utf8d interfaces
// Valid/ready channels for the byte stream going in and the decoded results
// coming out.
// ----------------------------------------------------------------------------
interface utf8d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface utf8d_rsp_if;
   logic        valid;
   logic        ready;
   logic [25:0] code_point;
   logic [1:0]  status;
   logic        end_of_string;

   modport source (output valid, output code_point, output status,
                   output end_of_string, input ready);
   modport sink   (input valid, input code_point, input status,
                   input end_of_string, output ready);
endinterface

// File: hw/rtl/utf8d_front.sv
// ----------------------------------------------------------------------------
// utf8d_front
// Accepts bytes from the request channel, classifies each one and holds it
// in a register until the queue takes it.
// ----------------------------------------------------------------------------
module utf8d_front (
   input  logic               clock,
   input  logic               reset,
   utf8d_req_if.sink          req,
   output logic               push_valid,
   input  logic               push_ready,
   output utf8d_pkg::item_type push_item
);
   import utf8d_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   item_type item_in;
   logic     accept;

   // classify the incoming byte by its lead bits
   always_comb begin
      item_in.data = req.data_byte;
      item_in.last = req.last_byte;
      priority if (!req.data_byte[7])          item_in.cls = CLS_ASCII;
      else if (!req.data_byte[6])              item_in.cls = CLS_CONT;
      else if (!req.data_byte[5])              item_in.cls = CLS_LEAD2;
      else if (!req.data_byte[4])              item_in.cls = CLS_LEAD3;
      else if (!req.data_byte[3])              item_in.cls = CLS_LEAD4;
      else if (!req.data_byte[2])              item_in.cls = CLS_LEAD5;
      else                                     item_in.cls = CLS_INVALID;
   end

   // stage empties into the queue: a new byte can enter each cycle it has room
   assign req.ready = !valid_ff || push_ready;
   assign accept    = req.valid && req.ready;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_item  = item_ff;

endmodule

// File: hw/rtl/utf8d_queue.sv
// ----------------------------------------------------------------------------
// utf8d_queue
// Short first-in first-out queue of classified bytes between the front and
// the back, so that each side stalls on its own.
// ----------------------------------------------------------------------------
module utf8d_queue #(
   parameter int DEPTH = utf8d_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  utf8d_pkg::item_type push_item,
   output logic                pop_valid,
   input  logic                pop_ready,
   output utf8d_pkg::item_type pop_item
);
   import utf8d_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type         entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = entries_ff[rd_ptr_ff];

   // pointer wrap and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: hw/rtl/utf8d_back.sv
// ----------------------------------------------------------------------------
// utf8d_back
// Decoder state machine: takes one classified byte a cycle from the queue
// while its output register is free or being read, gathers continuation
// bits and loads finished results into the output register.
// ----------------------------------------------------------------------------
module utf8d_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  utf8d_pkg::item_type pop_item,
   utf8d_rsp_if.source         rsp
);
   import utf8d_pkg::*;

   logic [REM_W-1:0] rem_ff;
   logic [REM_W-1:0] rem_in;
   logic [CP_W-1:0]  partial_ff;
   logic [CP_W-1:0]  partial_in;
   logic             failed_ff;
   logic             failed_in;

   logic             out_valid_ff;
   logic             out_valid_in;
   logic [CP_W-1:0]  out_cp_ff;
   status_type       out_status_ff;
   logic             out_eos_ff;

   logic             take;
   logic             emit;
   logic             bad;
   logic [CP_W-1:0]  res_cp;
   status_type       res_status;
   logic             res_eos;
   logic [CP_W-1:0]  shifted;
   logic [REM_W-1:0] rem_dec;

   assign pop_ready = !out_valid_ff || rsp.ready;
   assign take      = pop_valid && pop_ready;
   assign shifted   = {partial_ff[CP_W-7:0], pop_item.data[5:0]};
   assign rem_dec   = rem_ff - 1'b1;

   // next decoder state and the result of this transaction
   always_comb begin
      rem_in     = rem_ff;
      partial_in = partial_ff;
      failed_in  = failed_ff;
      emit       = 1'b0;
      bad        = 1'b0;
      res_cp     = '0;
      res_status = ST_CHAR;
      res_eos    = pop_item.last;
      if (take) begin
         if (failed_ff) begin
            // skip the rest of a failed string, report its end
            if (pop_item.last) begin
               emit       = 1'b1;
               res_status = ST_END_AFTER_ERROR;
               failed_in  = 1'b0;
            end
         end else if (rem_ff == '0) begin
            // lead byte
            unique case (pop_item.cls)
               CLS_ASCII: begin
                  emit   = 1'b1;
                  res_cp = CP_W'(pop_item.data);
               end
               CLS_LEAD2, CLS_LEAD3, CLS_LEAD4, CLS_LEAD5: begin
                  if (pop_item.last) begin
                     emit       = 1'b1;
                     res_status = ST_INCOMPLETE;
                  end else begin
                     unique case (pop_item.cls)
                        CLS_LEAD2: begin
                           rem_in     = REM_W'(1);
                           partial_in = CP_W'(pop_item.data[4:0]);
                        end
                        CLS_LEAD3: begin
                           rem_in     = REM_W'(2);
                           partial_in = CP_W'(pop_item.data[3:0]);
                        end
                        CLS_LEAD4: begin
                           rem_in     = REM_W'(3);
                           partial_in = CP_W'(pop_item.data[2:0]);
                        end
                        default: begin
                           rem_in     = REM_W'(4);
                           partial_in = CP_W'(pop_item.data[1:0]);
                        end
                     endcase
                  end
               end
               default: bad = 1'b1;
            endcase
         end else if (pop_item.cls == CLS_ASCII || pop_item.cls == CLS_CONT) begin
            // continuation byte (an ASCII byte is taken as one too), only its low six bits count
            if (rem_dec == '0) begin
               emit       = 1'b1;
               res_cp     = shifted;
               rem_in     = '0;
               partial_in = '0;
            end else if (pop_item.last) begin
               emit       = 1'b1;
               res_status = ST_INCOMPLETE;
               rem_in     = '0;
               partial_in = '0;
            end else begin
               rem_in     = rem_dec;
               partial_in = shifted;
            end
         end else begin
            bad = 1'b1;
         end

         // malformed byte: fail the string unless it ends here
         if (bad) begin
            emit       = 1'b1;
            res_status = ST_MALFORMED;
            rem_in     = '0;
            partial_in = '0;
            failed_in  = !pop_item.last;
         end
      end
   end

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff     <= '0;
         partial_ff <= '0;
         failed_ff  <= 1'b0;
      end else begin
         rem_ff     <= rem_in;
         partial_ff <= partial_in;
         failed_ff  <= failed_in;
      end
   end

   // output register
   always_comb begin
      if (take) begin
         out_valid_in = emit;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) begin
         out_cp_ff     <= res_cp;
         out_status_ff <= res_status;
         out_eos_ff    <= res_eos;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.code_point    = out_cp_ff;
   assign rsp.status        = out_status_ff;
   assign rsp.end_of_string = out_eos_ff;

endmodule

// File: hw/rtl/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Streaming decoder for UTF-8 with sequences of one to five bytes; gives one
// code point or status result per completed sequence, error or string end.
// ----------------------------------------------------------------------------
//
//   channel | dir | payload                                 | transaction
//   --------+-----+-----------------------------------------+------------------
//   req     | in  | data_byte[7:0], last_byte               | valid && ready
//   rsp     | out | code_point[25:0], status[1:0], end_of_string | valid && ready
//
// One byte per cycle sustained while rsp is ready; the back's shift-or state update
// takes a byte from the queue every cycle unless its output register is stalled.
// A result passes from its byte through the front register, queue and output
// register before it is shown on rsp.
// Reset is synchronous and empties the front register, queue and output
// register and clears the decoder state.
// A stalled rsp backs up into the queue; req stays ready until QUEUE_DEPTH
// bytes plus the front register are waiting.
// ----------------------------------------------------------------------------
module utf8_stream_decoder #(
   parameter int QUEUE_DEPTH = utf8d_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   utf8d_req_if.sink   req,
   utf8d_rsp_if.source rsp
);
   import utf8d_pkg::*;

   logic     push_valid;
   logic     push_ready;
   item_type push_item;
   logic     pop_valid;
   logic     pop_ready;
   item_type pop_item;

   // byte intake and classification
   utf8d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   // queue between front and back
   utf8d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // decoding and result register
   utf8d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp       (rsp)
   );

endmodule

// File: hw/rtl/utf8d_checker.sv
// ----------------------------------------------------------------------------
// utf8d_checker
// Port-level checks on the decoder's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module utf8d_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [25:0] rsp_code_point,
   input logic [1:0]  rsp_status,
   input logic        rsp_end_of_string
);
   import utf8d_pkg::*;

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // only a character carries a code point
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_CHAR) |-> (rsp_code_point == '0))
      else $error("code point nonzero on a status result");

   // incomplete end and end after error always close a string
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_INCOMPLETE || rsp_status == ST_END_AFTER_ERROR))
      |-> rsp_end_of_string)
      else $error("end status without end of string");

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_code_point)
      && $stable(rsp_status) && $stable(rsp_end_of_string)))
      else $error("stalled result changed");

endmodule

bind utf8_stream_decoder utf8d_checker u_utf8d_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_code_point    (rsp.code_point),
   .rsp_status        (rsp.status),
   .rsp_end_of_string (rsp.end_of_string)
);
